FILE: rtl/core/rtc_pkg.sv
// shared types and constants of the refrigerator thermal controller
package rtc_pkg;

  localparam int TMR_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int DIVN_W     = 14;
  localparam int DIVD_W     = 7;

  localparam logic [TMR_W-1:0] TMR_MAX = {TMR_W{1'b1}};

  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [3:0] PW_CENTER = 4'd12;
  localparam logic [1:0] PW_SPAN   = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SENSOR  = 2'd1,
    OP_DEFROST = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREEZER_SET  = 3'd0,
    REG_FRIDGE_SET   = 3'd1,
    REG_DEFROST_LIM  = 3'd2,
    REG_INTERVAL_HR  = 3'd3,
    REG_DURATION_MIN = 3'd4,
    REG_FREEZER_BAND = 3'd5,
    REG_FRIDGE_BAND  = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  localparam logic [6:0] RST_FREEZER_SET  = 7'h6E;  // -18
  localparam logic [4:0] RST_FRIDGE_SET   = 5'd2;
  localparam logic [5:0] RST_DEFROST_LIM  = 6'd5;
  localparam logic [4:0] RST_INTERVAL_HR  = 5'd6;
  localparam logic [5:0] RST_DURATION_MIN = 6'd20;
  localparam logic [3:0] RST_FREEZER_BAND = 4'd4;
  localparam logic [4:0] RST_FRIDGE_BAND  = 5'd8;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [7:0] fridge_temp;
    logic signed [7:0] freezer_temp;
    logic signed [7:0] defrost_temp;
  } in_item_t;

  typedef struct packed {
    logic       servo_pulse;
    logic       compressor_on;
    logic       defroster_on;
    logic [3:0] damper_width;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_FRAME,
    S_TICK_CHK,
    S_MANUAL,
    S_SENSOR,
    S_DIV1,
    S_DIV2,
    S_FIN
  } state_t;

endpackage

FILE: rtl/core/rtc_if.sv
// valid/ready channel interfaces for input items and result items
interface rtc_in_if
  import rtc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtc_out_if
  import rtc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rtc_div.sv
// restoring unsigned divider, one quotient bit per cycle
module rtc_div
  import rtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W:0]   trial;
  logic              fits;

  always_comb begin
    shifted  = {rem_r, quo_r[DIVN_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    fits     = (shifted >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIVN_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[DIVN_W-2:0], fits};
      rem_nxt  = fits ? trial[DIVD_W-1:0] : shifted[DIVD_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/core/refrigerator_thermal_controller.sv
// top level: tick, sensor and defrost sequencer around a shared divider
//
//   channel  dir  payload                                          transfer
//   in_if    in   opcode, fridge/freezer/defrost temperature       valid & ready
//   out_if   out  servo_pulse, compressor_on, defroster_on, width  valid & ready
//   cfg_*    in   cfg_index, cfg_wdata                             cfg_we
//
// ticks pass S_TICK_FRAME, S_TICK_CHK, manual defrost S_MANUAL, unused opcodes
// none before S_FIN; sensors make two 14-step divider passes (one at zero band).
// rst_n is synchronous; it clears all control state and loads register defaults.
// in_if.ready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next item is worked on meanwhile.
module refrigerator_thermal_controller
  import rtc_pkg::*;
#(
  parameter int FRAME_LIMIT      = 200,
  parameter int TICKS_PER_MINUTE = 3000,
  parameter int TICKS_PER_HOUR   = 180000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rtc_in_if.sink                in_if,
  rtc_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IV_W  = $clog2(31 * TICKS_PER_HOUR + 1);
  localparam int DU_W  = $clog2(63 * TICKS_PER_MINUTE + 1);
  localparam int CMP_W = (IV_W > TMR_W) ? ((IV_W > DU_W) ? IV_W : DU_W)
                                        : ((TMR_W > DU_W) ? TMR_W : DU_W);

  // configuration registers
  logic [6:0] freezer_set_r;
  logic [4:0] fridge_set_r;
  logic [5:0] defrost_lim_r;
  logic [4:0] interval_hr_r;
  logic [5:0] duration_min_r;
  logic [3:0] freezer_band_r;
  logic [4:0] fridge_band_r;

  state_t           state_r, state_nxt;
  logic [7:0]       frame_r, frame_nxt;
  logic [TMR_W-1:0] timer_r, timer_nxt;
  logic             pulse_r, pulse_nxt;
  logic             comp_r, comp_nxt;
  logic             defr_r, defr_nxt;
  logic [3:0]       pw_r, pw_nxt;
  logic             sign_r, sign_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             out_load;

  in_item_t         item_r;
  logic [IV_W-1:0]  iv_r;
  logic [DU_W-1:0]  du_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_xfer;
  logic [7:0]        frame_inc;
  logic signed [9:0] fz_s, on_thr, off_thr;
  logic signed [8:0] err;
  logic [7:0]        err_mag;
  logic [6:0]        q1_clamp;
  logic [1:0]        q2;

  rtc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_xfer   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    frame_inc = frame_r + 8'd1;
    fz_s      = 10'(item_r.freezer_temp);
    on_thr    = 10'($signed(freezer_set_r)) + $signed({6'b0, freezer_band_r});
    off_thr   = 10'($signed(freezer_set_r)) - $signed({6'b0, freezer_band_r});
    err       = 9'(item_r.fridge_temp) - 9'($signed(fridge_set_r));
    err_mag   = err[8] ? 8'(-err) : err[7:0];
    q1_clamp  = (div_rsp.quotient > DIVN_W'(PCT_SCALE)) ? PCT_SCALE
                                                       : div_rsp.quotient[6:0];
    q2        = div_rsp.quotient[1:0];

    state_nxt        = state_r;
    frame_nxt        = frame_r;
    timer_nxt        = timer_r;
    pulse_nxt        = pulse_r;
    comp_nxt         = comp_r;
    defr_nxt         = defr_r;
    pw_nxt           = pw_r;
    sign_nxt         = sign_r;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = {2'b0, fridge_band_r};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (opcode_t'(in_if.data.opcode))
            OP_TICK:    state_nxt = S_TICK_FRAME;
            OP_SENSOR:  state_nxt = S_SENSOR;
            OP_DEFROST: state_nxt = S_MANUAL;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_TICK_FRAME: begin
        if (frame_r > 8'(FRAME_LIMIT)) begin
          frame_nxt = '0;
          if (timer_r != TMR_MAX) begin
            timer_nxt = timer_r + 1'b1;
          end
          pulse_nxt = ({4'b0, pw_r} == 8'd0) ? 1'b0 : 1'b1;
        end else begin
          frame_nxt = frame_inc;
          if (frame_inc >= {4'b0, pw_r}) begin
            pulse_nxt = 1'b0;
          end
        end
        state_nxt = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        if (CMP_W'(timer_r) > CMP_W'(iv_r)) begin
          timer_nxt = '0;
          comp_nxt  = 1'b0;
          defr_nxt  = 1'b1;
        end else if (CMP_W'(timer_r) > CMP_W'(du_r)) begin
          defr_nxt = 1'b0;
        end
        state_nxt = S_FIN;
      end
      S_MANUAL: begin
        timer_nxt = (CMP_W'(iv_r) > CMP_W'(TMR_MAX)) ? TMR_MAX : TMR_W'(iv_r);
        state_nxt = S_FIN;
      end
      S_SENSOR: begin
        if (!defr_r) begin
          if (fz_s > on_thr) begin
            comp_nxt = 1'b1;
          end else if (fz_s < off_thr) begin
            comp_nxt = 1'b0;
          end
        end
        if ($signed(item_r.defrost_temp) > $signed(defrost_lim_r)) begin
          defr_nxt = 1'b0;
        end
        sign_nxt      = err[8];
        div_req.start = 1'b1;
        if (fridge_band_r == '0) begin
          // zero band: full deflection toward the sign of the error, none for zero error
          div_req.dividend = (err_mag == '0) ? '0
                                             : DIVN_W'(PCT_SCALE) * DIVN_W'(PW_SPAN);
          div_req.divisor  = PCT_SCALE;
          state_nxt        = S_DIV2;
        end else begin
          div_req.dividend = DIVN_W'(err_mag) * DIVN_W'(PCT_SCALE);
          state_nxt        = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVN_W'(q1_clamp) * DIVN_W'(PW_SPAN);
          div_req.divisor  = PCT_SCALE;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          pw_nxt    = sign_r ? (PW_CENTER - {2'b0, q2}) : (PW_CENTER + {2'b0, q2});
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_r        <= '0;
      timer_r        <= '0;
      pulse_r        <= 1'b0;
      comp_r         <= 1'b0;
      defr_r         <= 1'b0;
      pw_r           <= '0;
      sign_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      freezer_set_r  <= RST_FREEZER_SET;
      fridge_set_r   <= RST_FRIDGE_SET;
      defrost_lim_r  <= RST_DEFROST_LIM;
      interval_hr_r  <= RST_INTERVAL_HR;
      duration_min_r <= RST_DURATION_MIN;
      freezer_band_r <= RST_FREEZER_BAND;
      fridge_band_r  <= RST_FRIDGE_BAND;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      timer_r     <= timer_nxt;
      pulse_r     <= pulse_nxt;
      comp_r      <= comp_nxt;
      defr_r      <= defr_nxt;
      pw_r        <= pw_nxt;
      sign_r      <= sign_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FREEZER_SET:  freezer_set_r  <= cfg_wdata;
          REG_FRIDGE_SET:   fridge_set_r   <= cfg_wdata[4:0];
          REG_DEFROST_LIM:  defrost_lim_r  <= cfg_wdata[5:0];
          REG_INTERVAL_HR:  interval_hr_r  <= cfg_wdata[4:0];
          REG_DURATION_MIN: duration_min_r <= cfg_wdata[5:0];
          REG_FREEZER_BAND: freezer_band_r <= cfg_wdata[3:0];
          REG_FRIDGE_BAND:  fridge_band_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers; timer limits are taken from the registers at accept
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_if.data;
      iv_r   <= IV_W'(interval_hr_r) * IV_W'(TICKS_PER_HOUR);
      du_r   <= DU_W'(duration_min_r) * DU_W'(TICKS_PER_MINUTE);
    end
    if (out_load) begin
      out_data_r.servo_pulse   <= pulse_r;
      out_data_r.compressor_on <= comp_r;
      out_data_r.defroster_on  <= defr_r;
      out_data_r.damper_width  <= pw_r;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

`ifndef SYNTHESIS
  a_relays_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(comp_r && defr_r))
    else $error("compressor and defroster both on");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pw_r == 4'd0) || (pw_r >= 4'd9))
    else $error("damper width out of range");

  a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r <= 8'(FRAME_LIMIT + 1))
    else $error("frame counter passed its limit");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a divide state");

  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented after finishing an item");
`endif

endmodule
